[sv/mec_pkg.sv]
package mec_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int COUNT_W      = 16;
  localparam int VW           = $clog2(MAX_VERTICES);
  localparam int LIVE_W       = $clog2(MAX_VERTICES + 1);
  localparam int CELL_W       = 2 * VW;
  localparam int VIN_W        = 8;
  localparam int CFG_W        = 9;
  localparam int VL_W         = 9;
  localparam int SUM_W        = 24;
  localparam int ALU_W        = (COUNT_W > SUM_W) ? COUNT_W : SUM_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CFG_W-1:0]   NV_RESET  = CFG_W'(200);

  typedef enum logic [1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_ADD      = 2'd1,
    ACT_CONTRACT = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    STS_OK  = 2'd0,
    STS_BAD = 2'd1,
    STS_SAT = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_INIT, S_CLR, S_IDLE,
    S_ARS, S_ARD, S_AEM, S_AWR,
    S_CRLO, S_CRHI, S_CVST, S_CVCHK, S_CR, S_CA, S_CB, S_CZ1, S_CC, S_CD, S_CZ2,
    S_CZ, S_SHCHK, S_SHW,
    S_SUM0, S_SUM1, S_SV, S_SE, S_SA,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [VW-1:0]      sm_raddr;
    logic               sm_we;
    logic [VW-1:0]      sm_waddr;
    logic [VW-1:0]      sm_wdata;
    logic [CELL_W-1:0]  em_raddr;
    logic               em_we;
    logic [CELL_W-1:0]  em_waddr;
    logic [COUNT_W-1:0] em_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [VL_W-1:0]  vertices_left;
    logic [SUM_W-1:0] vertex0_edges;
    logic [1:0]       status;
  } res_t;

  function automatic logic [LIVE_W-1:0] clamp_nv(input logic [CFG_W-1:0] nv);
    logic [LIVE_W-1:0] r;
    if (int'(nv) > MAX_VERTICES) begin
      r = LIVE_W'(MAX_VERTICES);
    end else begin
      r = LIVE_W'(nv);
    end
    return r;
  endfunction

endpackage

[sv/mec_mem.sv]
module mec_mem
  import mec_pkg::*;
(
  input  logic               clk_i,
  input  mem_req_t           req_i,
  output logic [VW-1:0]      sm_rdata_o,
  output logic [COUNT_W-1:0] em_rdata_o
);

  logic [VW-1:0]      slot_mem [MAX_VERTICES];
  logic [COUNT_W-1:0] edge_mem [MAX_VERTICES*MAX_VERTICES];

  always_ff @(posedge clk_i) begin
    if (req_i.sm_we) begin
      slot_mem[req_i.sm_waddr] <= req_i.sm_wdata;
    end
    sm_rdata_o <= slot_mem[req_i.sm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.em_we) begin
      edge_mem[req_i.em_waddr] <= req_i.em_wdata;
    end
    em_rdata_o <= edge_mem[req_i.em_raddr];
  end

endmodule

[sv/mec_satadd.sv]
module mec_satadd
  import mec_pkg::*;
(
  input  logic [ALU_W-1:0] op_a_i,
  input  logic [ALU_W-1:0] op_b_i,
  input  logic [ALU_W-1:0] lim_i,
  output logic [ALU_W-1:0] sum_o,
  output logic             sat_o
);

  logic [ALU_W:0] raw;

  assign raw   = {1'b0, op_a_i} + {1'b0, op_b_i};
  assign sat_o = raw > {1'b0, lim_i};
  assign sum_o = sat_o ? lim_i : raw[ALU_W-1:0];

endmodule

[sv/mec_seq.sv]
module mec_seq
  import mec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [VIN_W-1:0]   first_vertex_i,
  input  logic [VIN_W-1:0]   second_vertex_i,
  input  logic [CFG_W-1:0]   num_vertices_i,
  output mem_req_t           mem_req_o,
  input  logic [VW-1:0]      sm_rdata_i,
  input  logic [COUNT_W-1:0] em_rdata_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output res_t               res_o
);

  state_e state_q, state_d;
  logic [CELL_W-1:0]  clr_q, clr_d;
  logic [LIVE_W-1:0]  live_q, live_d;
  logic [LIVE_W-1:0]  v_q, v_d;
  logic [1:0]         k_q, k_d;
  logic [VW-1:0]      a_q, a_d, b_q, b_d;
  logic [VW-1:0]      rlo_q, rlo_d, rhi_q, rhi_d, r_q, r_d;
  logic [COUNT_W-1:0] tmp_q, tmp_d;
  logic [SUM_W-1:0]   acc_q, acc_d;
  logic               sat_q, sat_d;
  status_e            status_q, status_d;

  logic [ALU_W-1:0] alu_a, alu_b, alu_lim, alu_y;
  logic             alu_sat;

  logic [VW-1:0]     lo, hi;
  logic              in_ok;
  logic              v_live, v_skip, sh_more;
  logic [LIVE_W-1:0] v_next;

  mec_satadd u_alu (
    .op_a_i (alu_a),
    .op_b_i (alu_b),
    .lim_i  (alu_lim),
    .sum_o  (alu_y),
    .sat_o  (alu_sat)
  );

  assign lo      = (a_q < b_q) ? a_q : b_q;
  assign hi      = (a_q < b_q) ? b_q : a_q;
  assign in_ok   = (int'(first_vertex_i) < int'(live_q)) &&
                   (int'(second_vertex_i) < int'(live_q)) &&
                   (first_vertex_i != second_vertex_i);
  assign v_live  = v_q < live_q;
  assign v_skip  = (v_q == LIVE_W'(lo)) || (v_q == LIVE_W'(hi));
  assign v_next  = v_q + LIVE_W'(1);
  assign sh_more = v_next < live_q;

  assign in_ready_o  = state_q == S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = '{vertices_left: VL_W'(live_q), vertex0_edges: acc_q,
                         status: status_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:  if (clr_q == '1) state_d = S_IDLE;
      S_CLR:   if (clr_q == '1) state_d = S_DONE;
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (act_e'(action_i))
            ACT_CLEAR:    state_d = S_CLR;
            ACT_ADD:      state_d = in_ok ? S_ARS : S_SUM0;
            ACT_CONTRACT: state_d = in_ok ? S_CRLO : S_SUM0;
            default:      state_d = S_SUM0;
          endcase
        end
      end
      S_ARS:   state_d = S_ARD;
      S_ARD:   state_d = S_AEM;
      S_AEM:   state_d = S_AWR;
      S_AWR:   state_d = S_SUM0;
      S_CRLO:  state_d = S_CRHI;
      S_CRHI:  state_d = S_CVST;
      S_CVST:  state_d = S_CVCHK;
      S_CVCHK: begin
        if (!v_live) begin
          state_d = S_CZ;
        end else if (!v_skip) begin
          state_d = S_CR;
        end
      end
      S_CR:    state_d = S_CA;
      S_CA:    state_d = S_CB;
      S_CB:    state_d = S_CZ1;
      S_CZ1:   state_d = S_CC;
      S_CC:    state_d = S_CD;
      S_CD:    state_d = S_CZ2;
      S_CZ2:   state_d = S_CVCHK;
      S_CZ:    if (k_q == 2'd3) state_d = S_SHCHK;
      S_SHCHK: state_d = sh_more ? S_SHW : S_SUM0;
      S_SHW:   state_d = S_SHCHK;
      S_SUM0:  state_d = S_SUM1;
      S_SUM1:  state_d = S_SV;
      S_SV:    state_d = v_live ? S_SE : S_DONE;
      S_SE:    state_d = S_SA;
      S_SA:    state_d = S_SV;
      S_DONE:  if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    clr_d     = clr_q;
    live_d    = live_q;
    v_d       = v_q;
    k_d       = k_q;
    a_d       = a_q;
    b_d       = b_q;
    rlo_d     = rlo_q;
    rhi_d     = rhi_q;
    r_d       = r_q;
    tmp_d     = tmp_q;
    acc_d     = acc_q;
    sat_d     = sat_q;
    status_d  = status_q;
    mem_req_o = '0;
    alu_a     = ALU_W'(tmp_q);
    alu_b     = ALU_W'(em_rdata_i);
    alu_lim   = ALU_W'(COUNT_MAX);
    unique case (state_q)
      S_INIT, S_CLR: begin
        // sweep every cell to zero, rebuild identity map during the first row
        mem_req_o.em_we    = 1'b1;
        mem_req_o.em_waddr = clr_q;
        mem_req_o.em_wdata = '0;
        if (clr_q[CELL_W-1:VW] == '0) begin
          mem_req_o.sm_we    = 1'b1;
          mem_req_o.sm_waddr = clr_q[VW-1:0];
          mem_req_o.sm_wdata = clr_q[VW-1:0];
        end
        clr_d = clr_q + CELL_W'(1);
        acc_d = '0;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          a_d      = VW'(first_vertex_i);
          b_d      = VW'(second_vertex_i);
          clr_d    = '0;
          sat_d    = 1'b0;
          status_d = STS_OK;
          unique case (act_e'(action_i))
            ACT_CLEAR:              live_d = clamp_nv(num_vertices_i);
            ACT_ADD, ACT_CONTRACT:  if (!in_ok) status_d = STS_BAD;
            default:                status_d = STS_OK;
          endcase
        end
      end
      S_ARS: mem_req_o.sm_raddr = a_q;
      S_ARD: begin
        rlo_d              = sm_rdata_i;
        mem_req_o.sm_raddr = b_q;
      end
      S_AEM: begin
        rhi_d              = sm_rdata_i;
        mem_req_o.em_raddr = {rlo_q, sm_rdata_i};
      end
      S_AWR: begin
        alu_a              = ALU_W'(em_rdata_i);
        alu_b              = ALU_W'(1);
        mem_req_o.em_we    = 1'b1;
        mem_req_o.em_waddr = {rlo_q, rhi_q};
        mem_req_o.em_wdata = alu_y[COUNT_W-1:0];
        status_d           = alu_sat ? STS_SAT : STS_OK;
      end
      S_CRLO: mem_req_o.sm_raddr = lo;
      S_CRHI: begin
        rlo_d              = sm_rdata_i;
        mem_req_o.sm_raddr = hi;
      end
      S_CVST: begin
        rhi_d = sm_rdata_i;
        v_d   = '0;
      end
      S_CVCHK: begin
        if (v_live) begin
          if (v_skip) begin
            v_d = v_next;
          end else begin
            mem_req_o.sm_raddr = v_q[VW-1:0];
          end
        end else begin
          k_d = '0;
        end
      end
      S_CR: begin
        r_d                = sm_rdata_i;
        mem_req_o.em_raddr = {rlo_q, sm_rdata_i};
      end
      S_CA: begin
        tmp_d              = em_rdata_i;
        mem_req_o.em_raddr = {rhi_q, r_q};
      end
      S_CB: begin
        mem_req_o.em_we    = 1'b1;
        mem_req_o.em_waddr = {rlo_q, r_q};
        mem_req_o.em_wdata = alu_y[COUNT_W-1:0];
        sat_d              = sat_q | alu_sat;
      end
      S_CZ1: begin
        mem_req_o.em_we    = 1'b1;
        mem_req_o.em_waddr = {rhi_q, r_q};
        mem_req_o.em_wdata = '0;
        mem_req_o.em_raddr = {r_q, rlo_q};
      end
      S_CC: begin
        tmp_d              = em_rdata_i;
        mem_req_o.em_raddr = {r_q, rhi_q};
      end
      S_CD: begin
        mem_req_o.em_we    = 1'b1;
        mem_req_o.em_waddr = {r_q, rlo_q};
        mem_req_o.em_wdata = alu_y[COUNT_W-1:0];
        sat_d              = sat_q | alu_sat;
      end
      S_CZ2: begin
        mem_req_o.em_we    = 1'b1;
        mem_req_o.em_waddr = {r_q, rhi_q};
        mem_req_o.em_wdata = '0;
        v_d                = v_next;
      end
      S_CZ: begin
        // drop the four cells among the merged pair
        mem_req_o.em_we    = 1'b1;
        mem_req_o.em_waddr = {(k_q[1] ? rhi_q : rlo_q), (k_q[0] ? rhi_q : rlo_q)};
        mem_req_o.em_wdata = '0;
        k_d                = k_q + 2'd1;
        v_d                = LIVE_W'(hi);
      end
      S_SHCHK: begin
        if (sh_more) begin
          mem_req_o.sm_raddr = v_next[VW-1:0];
        end else begin
          live_d   = live_q - LIVE_W'(1);
          status_d = sat_q ? STS_SAT : STS_OK;
        end
      end
      S_SHW: begin
        mem_req_o.sm_we    = 1'b1;
        mem_req_o.sm_waddr = v_q[VW-1:0];
        mem_req_o.sm_wdata = sm_rdata_i;
        v_d                = v_next;
      end
      S_SUM0: mem_req_o.sm_raddr = '0;
      S_SUM1: begin
        rlo_d = sm_rdata_i;
        v_d   = '0;
        acc_d = '0;
      end
      S_SV: if (v_live) mem_req_o.sm_raddr = v_q[VW-1:0];
      S_SE: mem_req_o.em_raddr = {rlo_q, sm_rdata_i};
      S_SA: begin
        alu_a   = ALU_W'(acc_q);
        alu_lim = ALU_W'(SUM_MAX);
        acc_d   = alu_y[SUM_W-1:0];
        v_d     = v_next;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      clr_q   <= '0;
      live_q  <= clamp_nv(NV_RESET);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      live_q  <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    k_q      <= k_d;
    a_q      <= a_d;
    b_q      <= b_d;
    rlo_q    <= rlo_d;
    rhi_q    <= rhi_d;
    r_q      <= r_d;
    tmp_q    <= tmp_d;
    acc_q    <= acc_d;
    sat_q    <= sat_d;
    status_q <= status_d;
  end

endmodule

[sv/multigraph_edge_contraction.sv]
// Edge contraction on a directed multigraph held as an edge-count matrix with one
// single-port-write, registered-read memory and a slot map; one item at a time, and
// in_ready_o stays low while an item is worked on. Clear sweeps all MAX_VERTICES^2
// (65536) matrix cells to zero, one per cycle; the same sweep runs right after reset
// before the first item is taken. Every other item ends with a vertex-0 row sum over
// the live vertices. Add-edge reads both slots and the edge cell and writes it back
// before that; contract first merges the rows and columns of the pair into the lower
// one for each other live vertex, then shifts the slot map down above the higher one.
// Action 3 and rejected vertices go straight to the sum. Results sit in an output
// register, so the next item is taken while one waits.
module multigraph_edge_contraction
  import mec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [VIN_W-1:0]   first_vertex_i,
  input  logic [VIN_W-1:0]   second_vertex_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [VL_W-1:0]    vertices_left_o,
  output logic [SUM_W-1:0]   vertex0_edges_o,
  output logic [1:0]         status_o
);

  logic [CFG_W-1:0]   nv_q;
  logic               out_valid_q;
  res_t               out_q;
  mem_req_t           mem_req;
  logic [VW-1:0]      sm_rdata;
  logic [COUNT_W-1:0] em_rdata;
  logic               res_valid, res_ready;
  res_t               res;

  mec_mem u_mem (
    .clk_i      (clk_i),
    .req_i      (mem_req),
    .sm_rdata_o (sm_rdata),
    .em_rdata_o (em_rdata)
  );

  mec_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .first_vertex_i  (first_vertex_i),
    .second_vertex_i (second_vertex_i),
    .num_vertices_i  (nv_q),
    .mem_req_o       (mem_req),
    .sm_rdata_i      (sm_rdata),
    .em_rdata_i      (em_rdata),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  assign cfg_ready_o = 1'b1;
  assign res_ready   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q        <= NV_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        nv_q <= cfg_data_i;
      end
      if (res_ready) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vertices_left_o = out_q.vertices_left;
  assign vertex0_edges_o = out_q.vertex0_edges;
  assign status_o        = out_q.status;

endmodule

[sv/mec_checker.sv]
module mec_checker
  import mec_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CFG_W-1:0]   cfg_data_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         action_i,
  input logic [VIN_W-1:0]   first_vertex_i,
  input logic [VIN_W-1:0]   second_vertex_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [VL_W-1:0]    vertices_left_o,
  input logic [SUM_W-1:0]   vertex0_edges_o,
  input logic [1:0]         status_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("block ready right after taking an item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(vertices_left_o) &&
      $stable(vertex0_edges_o) && $stable(status_o))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(vertices_left_o) <= MAX_VERTICES)
    else $error("vertex count above capacity");

endmodule

bind multigraph_edge_contraction mec_checker u_mec_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import mec_pkg::*;

  localparam int      LIMIT_CYCLES = 20_000_000;
  localparam int      TAIL_CYCLES  = 2000;
  localparam int      HOLD_CYCLES  = 3000;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  typedef struct {
    logic [1:0]       act;
    logic [VIN_W-1:0] va;
    logic [VIN_W-1:0] vb;
    bit               typed;
    logic [VL_W-1:0]  vl;
    logic [SUM_W-1:0] edges;
    status_e          st;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_W-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         action_i = '0;
  logic [VIN_W-1:0]   first_vertex_i = '0;
  logic [VIN_W-1:0]   second_vertex_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [VL_W-1:0]    vertices_left_o;
  logic [SUM_W-1:0]   vertex0_edges_o;
  logic [1:0]         status_o;

  // shadow copy of the graph
  logic [COUNT_W-1:0] gr_count [0:MAX_VERTICES*MAX_VERTICES-1];
  logic [VW-1:0]      gr_slot  [0:MAX_VERTICES-1];
  int                 gr_live;
  int                 gr_nv;

  res_t               exp_q [$];
  int                 err_cnt = 0;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 hold_ask = 0;
  int                 hold_done = 0;
  int                 hold_left = 0;
  longint             cyc = 0;

  multigraph_edge_contraction u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .first_vertex_i  (first_vertex_i),
    .second_vertex_i (second_vertex_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .vertices_left_o (vertices_left_o),
    .vertex0_edges_o (vertex0_edges_o),
    .status_o        (status_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int cidx(input logic [VW-1:0] r, input logic [VW-1:0] c);
    return int'({r, c});
  endfunction

  function automatic void graph_clear();
    for (int i = 0; i < MAX_VERTICES * MAX_VERTICES; i++) gr_count[i] = '0;
    for (int i = 0; i < MAX_VERTICES; i++) gr_slot[i] = VW'(i);
    gr_live = (gr_nv > MAX_VERTICES) ? MAX_VERTICES : gr_nv;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_sum(input logic [COUNT_W-1:0] x,
                                                 input logic [COUNT_W-1:0] y,
                                                 inout bit sat);
    longint s;
    s = longint'(x) + longint'(y);
    if (s > longint'(COUNT_MAX)) begin
      sat = 1'b1;
      return COUNT_MAX;
    end
    return COUNT_W'(s);
  endfunction

  function automatic status_e graph_add(input int s, input int d);
    int k;
    if (s >= gr_live || d >= gr_live || s == d) return STS_BAD;
    k = cidx(gr_slot[s], gr_slot[d]);
    if (gr_count[k] == COUNT_MAX) return STS_SAT;
    gr_count[k] = gr_count[k] + 1'b1;
    return STS_OK;
  endfunction

  function automatic status_e graph_contract(input int a, input int b);
    int lo, hi;
    logic [VW-1:0] rlo, rhi, r;
    bit sat;
    sat = 1'b0;
    if (a >= gr_live || b >= gr_live || a == b) return STS_BAD;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    rlo = gr_slot[lo];
    rhi = gr_slot[hi];
    for (int v = 0; v < gr_live; v++) begin
      if (v != lo && v != hi) begin
        r = gr_slot[v];
        gr_count[cidx(rlo, r)] = sat_sum(gr_count[cidx(rlo, r)], gr_count[cidx(rhi, r)], sat);
        gr_count[cidx(r, rlo)] = sat_sum(gr_count[cidx(r, rlo)], gr_count[cidx(r, rhi)], sat);
        gr_count[cidx(rhi, r)] = '0;
        gr_count[cidx(r, rhi)] = '0;
      end
    end
    gr_count[cidx(rlo, rlo)] = '0;
    gr_count[cidx(rlo, rhi)] = '0;
    gr_count[cidx(rhi, rlo)] = '0;
    gr_count[cidx(rhi, rhi)] = '0;
    for (int v = hi; v + 1 < gr_live; v++) gr_slot[v] = gr_slot[v+1];
    gr_live--;
    return sat ? STS_SAT : STS_OK;
  endfunction

  function automatic res_t graph_step(input logic [1:0] act, input int a, input int b);
    res_t    res;
    status_e st;
    longint  s;
    st = STS_OK;
    case (act)
      ACT_CLEAR:    graph_clear();
      ACT_ADD:      st = graph_add(a, b);
      ACT_CONTRACT: st = graph_contract(a, b);
      default:      st = STS_OK;
    endcase
    s = 0;
    for (int v = 0; v < gr_live; v++) begin
      s += longint'(gr_count[cidx(gr_slot[0], gr_slot[v])]);
      if (s > longint'(SUM_MAX)) s = longint'(SUM_MAX);
    end
    res.vertices_left = VL_W'(gr_live);
    res.vertex0_edges = SUM_W'(s);
    res.status        = st;
    return res;
  endfunction

  // receiver: random stall, long hold-off on request, and the compare
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_q.size() == 0) begin
        $error("result with nothing expected: vl=%0d edges=%0d status=%0d",
               vertices_left_o, vertex0_edges_o, status_o);
        err_cnt++;
      end else begin
        want = exp_q.pop_front();
        if (vertices_left_o !== want.vertices_left) begin
          $error("vertices_left exp %0d got %0d", want.vertices_left, vertices_left_o);
          err_cnt++;
        end
        if (vertex0_edges_o !== want.vertex0_edges) begin
          $error("vertex0_edges exp %0d got %0d", want.vertex0_edges, vertex0_edges_o);
          err_cnt++;
        end
        if (status_o !== want.status) begin
          $error("status exp %0d got %0d", want.status, status_o);
          err_cnt++;
        end
      end
    end
    if (hold_ask != hold_done) begin
      hold_done = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic [1:0] act, input int a, input int b,
                           input bit typed, input res_t typed_res);
    res_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    r = graph_step(act, a, b);
    exp_q.insert(exp_q.size(), typed ? typed_res : r);
    in_valid_i      <= 1'b1;
    action_i        <= act;
    first_vertex_i  <= VIN_W'(a);
    second_vertex_i <= VIN_W'(b);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (exp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_nv(input int nv);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= CFG_W'(nv);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    gr_nv = nv;
  endtask

  task automatic run_random(input int n_items, input int nv, input int idle, input int stall,
                            input bit pressure);
    int a, b, pick;
    res_t none;
    none = '0;
    write_nv(nv);
    idle_pct  = idle;
    stall_pct = stall;
    send_item(ACT_CLEAR, 0, 0, 1'b0, none);
    if (pressure) hold_ask++;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      a = $urandom_range(gr_live - 1);
      b = $urandom_range(gr_live - 1);
      if (pick < 70) begin
        send_item(ACT_ADD, a, b, 1'b0, none);
      end else if (pick < 82) begin
        // keep a few vertices alive so adds stay meaningful
        if (gr_live > 3) send_item(ACT_CONTRACT, a, b, 1'b0, none);
        else send_item(ACT_ADD, a, b, 1'b0, none);
      end else if (pick < 95) begin
        send_item($urandom_range(2) == 0 ? ACT_CONTRACT : ACT_ADD,
                  $urandom_range(255), $urandom_range(255), 1'b0, none);
      end else begin
        send_item(ACT_NOP, $urandom_range(255), $urandom_range(255), 1'b0, none);
      end
    end
  endtask

  function automatic dir_row_t mk(input logic [1:0] act, input int a, input int b,
                                  input bit typed, input int vl, input int edges,
                                  input status_e st);
    dir_row_t d;
    d.act = act; d.va = VIN_W'(a); d.vb = VIN_W'(b);
    d.typed = typed; d.vl = VL_W'(vl); d.edges = SUM_W'(edges); d.st = st;
    return d;
  endfunction

  initial begin
    dir_row_t rows [$];
    res_t     tr;
    gr_nv = 200;
    graph_clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, default vertex count
    rows.insert(rows.size(), mk(ACT_ADD,      0,   1,   1, 200, 1, STS_OK));
    rows.insert(rows.size(), mk(ACT_ADD,      0,   0,   1, 200, 1, STS_BAD));
    rows.insert(rows.size(), mk(ACT_ADD,      200, 1,   1, 200, 1, STS_BAD));
    rows.insert(rows.size(), mk(ACT_ADD,      255, 255, 1, 200, 1, STS_BAD));
    rows.insert(rows.size(), mk(ACT_NOP,      255, 0,   1, 200, 1, STS_OK));
    rows.insert(rows.size(), mk(ACT_ADD,      1,   0,   0, 0, 0, STS_OK));
    rows.insert(rows.size(), mk(ACT_ADD,      0,   199, 1, 200, 2, STS_OK));
    rows.insert(rows.size(), mk(ACT_ADD,      199, 2,   0, 0, 0, STS_OK));
    rows.insert(rows.size(), mk(ACT_CONTRACT, 199, 0,   0, 0, 0, STS_OK));
    rows.insert(rows.size(), mk(ACT_CONTRACT, 5,   5,   1, 199, 2, STS_BAD));
    rows.insert(rows.size(), mk(ACT_CONTRACT, 0,   199, 1, 199, 2, STS_BAD));
    rows.insert(rows.size(), mk(ACT_CONTRACT, 1,   0,   0, 0, 0, STS_OK));
    rows.insert(rows.size(), mk(ACT_CONTRACT, 198, 197, 0, 0, 0, STS_OK));
    rows.insert(rows.size(), mk(ACT_CLEAR,    0,   0,   1, 200, 0, STS_OK));
    foreach (rows[i]) begin
      tr.vertices_left = rows[i].vl;
      tr.vertex0_edges = rows[i].edges;
      tr.status        = rows[i].st;
      send_item(rows[i].act, rows[i].va, rows[i].vb, rows[i].typed, tr);
    end

    // smallest graph: contract down to one vertex
    write_nv(2);
    rows.delete();
    rows.insert(rows.size(), mk(ACT_CLEAR,    0, 0, 1, 2, 0, STS_OK));
    rows.insert(rows.size(), mk(ACT_ADD,      0, 1, 1, 2, 1, STS_OK));
    rows.insert(rows.size(), mk(ACT_ADD,      1, 0, 1, 2, 1, STS_OK));
    rows.insert(rows.size(), mk(ACT_CONTRACT, 1, 0, 1, 1, 0, STS_OK));
    rows.insert(rows.size(), mk(ACT_ADD,      0, 1, 1, 1, 0, STS_BAD));
    rows.insert(rows.size(), mk(ACT_CONTRACT, 0, 1, 1, 1, 0, STS_BAD));
    foreach (rows[i]) begin
      tr.vertices_left = rows[i].vl;
      tr.vertex0_edges = rows[i].edges;
      tr.status        = rows[i].st;
      send_item(rows[i].act, rows[i].va, rows[i].vb, rows[i].typed, tr);
    end

    // empty graph, then oversized count that clamps
    write_nv(0);
    tr = '{vertices_left: 0, vertex0_edges: 0, status: STS_OK};
    send_item(ACT_CLEAR, 0, 0, 1, tr);
    tr.status = STS_BAD;
    send_item(ACT_ADD, 0, 0, 1, tr);
    write_nv(511);
    tr = '{vertices_left: 256, vertex0_edges: 0, status: STS_OK};
    send_item(ACT_CLEAR, 0, 0, 1, tr);
    send_item(ACT_ADD, 0, 255, 0, tr);
    send_item(ACT_ADD, 255, 0, 0, tr);
    send_item(ACT_CONTRACT, 255, 0, 0, tr);

    run_random(290, $urandom_range(20, 60), 0,  0,  1'b1);
    run_random(290, $urandom_range(3, 40),  84, 0,  1'b0);
    run_random(290, $urandom_range(20, 60), 0,  84, 1'b0);
    run_random(270, 256,                    29, 29, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
